// ----- hdl/sic_pkg.sv -----
// Shared types, constants and a helper function of the secondary interrupt controller.
`timescale 1ns / 1ps

package sic_pkg;

  localparam int NUM_BANKS_DEF      = 2;
  localparam int LINES_PER_BANK_DEF = 32;
  localparam int OUT_BANKS          = 2;
  localparam int DATA_W             = 32;
  localparam int LEVEL_W            = OUT_BANKS * DATA_W;
  localparam int IDX_W              = 6;
  localparam logic [IDX_W-1:0] NONE_PENDING = IDX_W'(32);

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } sic_mode_t;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_EN_CLR   = 3'd1,
    REG_EN_SET   = 3'd2,
    REG_TYPE     = 3'd3,
    REG_POLARITY = 3'd4,
    REG_STATUS   = 3'd5,
    REG_CLEAR    = 3'd6,
    REG_UNUSED   = 3'd7
  } sic_reg_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    sic_reg_t          sel;
    logic [DATA_W-1:0] wdata;
  } sic_access_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              req;
    logic [IDX_W-1:0]  lowest;
  } sic_bank_res_t;

  // Index of the lowest set bit, or NONE_PENDING when no bit is set.
  function automatic logic [IDX_W-1:0] lowest_index(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] onehot;
    logic [IDX_W-1:0]  idx;
    onehot = v & (~v + DATA_W'(1));
    idx    = '0;
    for (int k = 0; k < DATA_W; k++) begin
      if (onehot[k]) begin
        idx = idx | IDX_W'(k);
      end
    end
    if (v == '0) begin
      idx = NONE_PENDING;
    end
    return idx;
  endfunction

endpackage

// ----- hdl/sic_if.sv -----
// Valid/ready channel interfaces for the request and result items.
`timescale 1ns / 1ps

interface sic_in_if
  import sic_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic               bank;
  logic [2:0]         reg_select;
  logic [DATA_W-1:0]  write_data;
  logic [LEVEL_W-1:0] line_levels;

  modport source (output valid, mode, bank, reg_select, write_data, line_levels,
                  input ready);
  modport sink   (input valid, mode, bank, reg_select, write_data, line_levels,
                  output ready);
endinterface

interface sic_out_if
  import sic_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [1:0]        cascade_request;
  logic [IDX_W-1:0]  lowest_pending_bank0;
  logic [IDX_W-1:0]  lowest_pending_bank1;

  modport source (output valid, read_data, cascade_request, lowest_pending_bank0,
                  lowest_pending_bank1, input ready);
  modport sink   (input valid, read_data, cascade_request, lowest_pending_bank0,
                  lowest_pending_bank1, output ready);
endinterface

// ----- hdl/sic_bank.sv -----
// One bank of interrupt lines: registers, edge and level sampling, pending priority.
`timescale 1ns / 1ps

module sic_bank
  import sic_pkg::*;
#(
  parameter int LINES = LINES_PER_BANK_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  sic_access_t       acc,
  input  logic [LINES-1:0]  raw,
  output sic_bank_res_t     res
);

  logic [LINES-1:0] enable_r, edge_mode_r, active_low_r, latch_r, prev_r;
  logic [LINES-1:0] enable_nxt, edge_mode_nxt, active_low_nxt, latch_nxt, prev_nxt;
  logic [LINES-1:0] wd, latch_acc, act, pend_now, pend_nxt;

  assign wd       = acc.wdata[LINES-1:0];
  assign pend_now = ((prev_r & ~edge_mode_r) | (latch_r & edge_mode_r)) & enable_r;

  always_comb begin
    enable_nxt     = enable_r;
    edge_mode_nxt  = edge_mode_r;
    active_low_nxt = active_low_r;
    latch_acc      = latch_r;
    if (acc.wr) begin
      unique case (acc.sel)
        REG_EN_CLR:   enable_nxt     = enable_r & ~wd;
        REG_EN_SET:   enable_nxt     = enable_r | wd;
        REG_TYPE:     edge_mode_nxt  = wd;
        REG_POLARITY: active_low_nxt = wd;
        REG_CLEAR:    latch_acc      = latch_r & ~wd;
        default:      ;
      endcase
    end
    // The access takes effect before this item's levels are sampled.
    act       = raw ^ active_low_nxt;
    latch_nxt = (latch_acc | (act & ~prev_r)) & edge_mode_nxt;
    prev_nxt  = act;
    pend_nxt  = ((prev_nxt & ~edge_mode_nxt) | (latch_nxt & edge_mode_nxt)) & enable_nxt;
  end

  always_comb begin
    res.rdata = '0;
    if (acc.rd) begin
      unique case (acc.sel)
        REG_ENABLE:   res.rdata = DATA_W'(enable_r);
        REG_TYPE:     res.rdata = DATA_W'(edge_mode_r);
        REG_POLARITY: res.rdata = DATA_W'(active_low_r);
        REG_STATUS:   res.rdata = DATA_W'(pend_now);
        default:      res.rdata = '0;
      endcase
    end
    res.req    = |pend_nxt;
    res.lowest = lowest_index(DATA_W'(pend_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= '0;
      edge_mode_r  <= '0;
      active_low_r <= '0;
      latch_r      <= '0;
      prev_r       <= '0;
    end else if (adv) begin
      enable_r     <= enable_nxt;
      edge_mode_r  <= edge_mode_nxt;
      active_low_r <= active_low_nxt;
      latch_r      <= latch_nxt;
      prev_r       <= prev_nxt;
    end
  end

endmodule

// ----- hdl/secondary_interrupt_controller_unit.sv -----
// Top level of the secondary interrupt controller: input register, banks, result register.
//
// Each request item on in_chan carries an optional register access (mode, bank,
// reg_select, write_data) and the raw levels of all lines, bank 1 in the upper
// half of line_levels. The access acts first, then the levels are sampled.
// Each request item yields exactly one result item on out_chan with the read
// data, a cascade request bit per bank and the lowest pending enabled line of
// each bank, 32 when none pends.
// An item is taken into an input register, worked on by one pass of bank logic
// and placed in a result register, from which its result is offered on out_chan.
// One item is accepted every cycle as long as out_chan takes
// results; the input register and result register are the only stages.
// When out_chan stalls, the result is held and the input register still fills,
// after which in_chan.ready drops until the stall clears. No item is lost.
// Synchronous reset clears all enable, type, polarity, latch and sampled-level
// bits and empties both registers.
`timescale 1ns / 1ps

module secondary_interrupt_controller_unit
  import sic_pkg::*;
#(
  parameter int NUM_BANKS      = NUM_BANKS_DEF,
  parameter int LINES_PER_BANK = LINES_PER_BANK_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sic_in_if.sink    in_chan,
  sic_out_if.source out_chan
);

  logic               in_vld_r;
  logic [1:0]         mode_r;
  logic               bank_r;
  sic_reg_t           sel_r;
  logic [DATA_W-1:0]  wdata_r;
  logic [LEVEL_W-1:0] levels_r;

  logic               out_vld_r;
  logic [DATA_W-1:0]  rdata_r, rdata_nxt;
  logic [1:0]         req_r, req_nxt;
  logic [IDX_W-1:0]   low0_r, low0_nxt, low1_r, low1_nxt;

  logic               adv;
  sic_bank_res_t      bank_res [NUM_BANKS];

  assign adv           = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || adv;

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    sic_access_t            acc;
    logic [LINES_PER_BANK-1:0] raw;
    logic                   hit;

    assign hit       = (b < OUT_BANKS) && (bank_r == 1'(b));
    assign acc.rd    = hit && (mode_r == MODE_READ);
    assign acc.wr    = hit && (mode_r == MODE_WRITE);
    assign acc.sel   = sel_r;
    assign acc.wdata = wdata_r;

    if (b < OUT_BANKS) begin : g_raw
      assign raw = levels_r[b*DATA_W +: LINES_PER_BANK];
    end else begin : g_tie
      assign raw = '0;
    end

    sic_bank #(.LINES(LINES_PER_BANK)) u_bank (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .acc   (acc),
      .raw   (raw),
      .res   (bank_res[b])
    );
  end

  always_comb begin
    rdata_nxt = '0;
    req_nxt   = '0;
    low0_nxt  = NONE_PENDING;
    low1_nxt  = NONE_PENDING;
    for (int b = 0; b < NUM_BANKS; b++) begin
      rdata_nxt = rdata_nxt | bank_res[b].rdata;
    end
    req_nxt[0] = bank_res[0].req;
    low0_nxt   = bank_res[0].lowest;
    if (NUM_BANKS > 1) begin
      req_nxt[1] = bank_res[NUM_BANKS > 1 ? 1 : 0].req;
      low1_nxt   = bank_res[NUM_BANKS > 1 ? 1 : 0].lowest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_vld_r <= in_chan.valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      mode_r   <= in_chan.mode;
      bank_r   <= in_chan.bank;
      sel_r    <= sic_reg_t'(in_chan.reg_select);
      wdata_r  <= in_chan.write_data;
      levels_r <= in_chan.line_levels;
    end
    if (adv) begin
      rdata_r <= rdata_nxt;
      req_r   <= req_nxt;
      low0_r  <= low0_nxt;
      low1_r  <= low1_nxt;
    end
  end

  assign out_chan.valid                = out_vld_r;
  assign out_chan.read_data            = rdata_r;
  assign out_chan.cascade_request      = req_r;
  assign out_chan.lowest_pending_bank0 = low0_r;
  assign out_chan.lowest_pending_bank1 = low1_r;

endmodule

// ----- dv/tb.sv -----
// Testbench for the secondary interrupt controller, with a predictor and result checker.
`timescale 1ns / 1ps

module tb;
  import sic_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [1:0]        req;
    logic [IDX_W-1:0]  low0;
    logic [IDX_W-1:0]  low1;
  } irq_result_t;

  logic clk;
  logic rst_n;

  sic_in_if  req_ch ();
  sic_out_if res_ch ();

  secondary_interrupt_controller_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_ch),
    .out_chan (res_ch)
  );

  logic [DATA_W-1:0] line_enable [2];
  logic [DATA_W-1:0] edge_mode   [2];
  logic [DATA_W-1:0] active_low  [2];
  logic [DATA_W-1:0] edge_latch  [2];
  logic [DATA_W-1:0] prev_active [2];

  irq_result_t        expected_results [$];
  int                 fail_count;
  bit                 idling_on;
  int                 hold_request;
  int                 hold_left;
  int                 stall_left;
  logic [LEVEL_W-1:0] cur_levels;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] pending_lines(int b);
    return ((prev_active[b] & ~edge_mode[b]) | (edge_latch[b] & edge_mode[b]))
           & line_enable[b];
  endfunction

  function automatic logic [IDX_W-1:0] lowest_line(logic [DATA_W-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = IDX_W'(32);
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  // The bus access acts first, then all line levels are sampled.
  function automatic irq_result_t predict_interrupts(logic [1:0] mode, logic bank,
                                                     logic [2:0] sel,
                                                     logic [DATA_W-1:0] wd,
                                                     logic [LEVEL_W-1:0] levels);
    irq_result_t       r;
    logic [DATA_W-1:0] act;
    r = '0;
    if (mode == MODE_READ) begin
      case (sel)
        REG_ENABLE:   r.rdata = line_enable[bank];
        REG_TYPE:     r.rdata = edge_mode[bank];
        REG_POLARITY: r.rdata = active_low[bank];
        REG_STATUS:   r.rdata = pending_lines(bank);
        default:      r.rdata = '0;
      endcase
    end else if (mode == MODE_WRITE) begin
      case (sel)
        REG_EN_CLR:   line_enable[bank] = line_enable[bank] & ~wd;
        REG_EN_SET:   line_enable[bank] = line_enable[bank] | wd;
        REG_TYPE:     edge_mode[bank]   = wd;
        REG_POLARITY: active_low[bank]  = wd;
        REG_CLEAR:    edge_latch[bank]  = edge_latch[bank] & ~wd;
        default: ;
      endcase
    end
    for (int b = 0; b < 2; b++) begin
      act = levels[DATA_W*b +: DATA_W] ^ active_low[b];
      edge_latch[b]  = (edge_latch[b] | (act & ~prev_active[b])) & edge_mode[b];
      prev_active[b] = act;
    end
    r.req  = {|pending_lines(1), |pending_lines(0)};
    r.low0 = lowest_line(pending_lines(0));
    r.low1 = lowest_line(pending_lines(1));
    return r;
  endfunction

  task automatic send_item(logic [1:0] mode, logic bank, logic [2:0] sel,
                           logic [DATA_W-1:0] wd, logic [LEVEL_W-1:0] levels);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= mode;
    req_ch.bank        <= bank;
    req_ch.reg_select  <= sel;
    req_ch.write_data  <= wd;
    req_ch.line_levels <= levels;
    do @(posedge clk); while (!req_ch.ready);
    expected_results.push_back(predict_interrupts(mode, bank, sel, wd, levels));
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic send_random_item();
    logic [1:0]        mode;
    logic [DATA_W-1:0] wd;
    int                pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      mode = MODE_NONE;
    end else if (pick < 6) begin
      mode = MODE_READ;
    end else if (pick < 9) begin
      mode = MODE_WRITE;
    end else begin
      mode = MODE_SPARE;
    end
    case ($urandom_range(0, 4))
      0:       wd = $urandom;
      1:       wd = DATA_W'(1) << $urandom_range(0, 31);
      2:       wd = ~(DATA_W'(1) << $urandom_range(0, 31));
      3:       wd = $urandom & $urandom & $urandom;
      default: wd = $urandom_range(0, 1) ? '1 : '0;
    endcase
    case ($urandom_range(0, 7))
      0:       cur_levels = {$urandom, $urandom};
      1:       cur_levels = ~cur_levels;
      2:       cur_levels = $urandom_range(0, 1) ? '1 : '0;
      default: cur_levels = cur_levels ^ (LEVEL_W'(1) << $urandom_range(0, 63))
                                       ^ (LEVEL_W'(1) << $urandom_range(0, 63));
    endcase
    send_item(mode, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), wd, cur_levels);
  endtask

  task automatic test_register_defaults();
    for (int s = 0; s < 8; s++) begin
      send_item(MODE_READ, 1'b0, 3'(s), '1, '0);
    end
  endtask

  task automatic test_line_modes();
    send_item(MODE_WRITE, 1'b0, REG_EN_SET, '1, '1);
    send_item(MODE_WRITE, 1'b1, REG_EN_SET, '1, 64'h8000_0000_8000_0000);
    send_item(MODE_READ, 1'b0, REG_STATUS, '0, '0);
    send_item(MODE_WRITE, 1'b1, REG_TYPE, '1, '0);
    send_item(MODE_NONE, 1'b0, REG_ENABLE, '0, 64'h0000_0001_0000_0000);
    send_item(MODE_NONE, 1'b0, REG_ENABLE, '0, '0);
    send_item(MODE_READ, 1'b1, REG_STATUS, '0, '0);
    // A clear written together with a fresh edge leaves the line latched.
    send_item(MODE_WRITE, 1'b1, REG_CLEAR, 32'h1, 64'h0000_0001_0000_0000);
    send_item(MODE_WRITE, 1'b1, REG_CLEAR, '1, 64'h0000_0001_0000_0000);
    // Flipping the polarity of an edge line counts as an edge.
    send_item(MODE_WRITE, 1'b1, REG_POLARITY, 32'h2, '0);
    send_item(MODE_WRITE, 1'b0, REG_POLARITY, '1, '0);
    send_item(MODE_READ, 1'b0, REG_POLARITY, '0, '0);
    send_item(MODE_SPARE, 1'b0, REG_ENABLE, '0, '1);
    send_item(MODE_WRITE, 1'b0, REG_ENABLE, '0, '0);
    send_item(MODE_WRITE, 1'b0, REG_STATUS, '0, '0);
    send_item(MODE_WRITE, 1'b0, REG_UNUSED, '0, '0);
    send_item(MODE_WRITE, 1'b0, REG_EN_CLR, 32'h7FFF_FFFF, '0);
    send_item(MODE_READ, 1'b0, REG_ENABLE, '0, '0);
    send_item(MODE_READ, 1'b1, REG_TYPE, '0, 64'hFFFF_FFFF_0000_0000);
  endtask

  task automatic test_backpressure();
    hold_request = 300;
    for (int n = 0; n < 40; n++) begin
      send_random_item();
    end
    drain_results();
  endtask

  task automatic test_random_traffic(int count);
    for (int n = 0; n < count; n++) begin
      send_random_item();
    end
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    irq_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation waiting");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_ch.read_data !== want.rdata) begin
          $error("read_data: expected %h, got %h", want.rdata, res_ch.read_data);
          fail_count++;
        end
        if (res_ch.cascade_request !== want.req) begin
          $error("cascade_request: expected %b, got %b", want.req, res_ch.cascade_request);
          fail_count++;
        end
        if (res_ch.lowest_pending_bank0 !== want.low0) begin
          $error("lowest_pending_bank0: expected %0d, got %0d", want.low0,
                 res_ch.lowest_pending_bank0);
          fail_count++;
        end
        if (res_ch.lowest_pending_bank1 !== want.low1) begin
          $error("lowest_pending_bank1: expected %0d, got %0d", want.low1,
                 res_ch.lowest_pending_bank1);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.mode        = MODE_NONE;
    req_ch.bank        = 1'b0;
    req_ch.reg_select  = REG_ENABLE;
    req_ch.write_data  = '0;
    req_ch.line_levels = '0;
    res_ch.ready       = 1'b0;
    fail_count         = 0;
    hold_request       = 0;
    hold_left          = 0;
    stall_left         = 0;
    cur_levels         = '0;
    idling_on          = 1'b1;
    for (int b = 0; b < 2; b++) begin
      line_enable[b] = '0;
      edge_mode[b]   = '0;
      active_low[b]  = '0;
      edge_latch[b]  = '0;
      prev_active[b] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_register_defaults();
    test_line_modes();
    test_backpressure();
    test_random_traffic(1780);
    idling_on = 1'b0;
    test_random_traffic(100);
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- secondary_interrupt_controller_unit.f -----
hdl/sic_pkg.sv
hdl/sic_if.sv
hdl/sic_bank.sv
hdl/secondary_interrupt_controller_unit.sv
dv/tb.sv
